// ----- rtl/bpvm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bpvm_pkg
// shared constants for the phase voltage modulator
// ----------------------------------------------------------------------------
package bpvm_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_MODE    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CENTER  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LIMIT   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SUPPLY  = 2'd3;

  localparam logic [16:0] SIN_A = 17'd102944;
  localparam logic [15:0] SIN_B = 16'd42047;
  localparam logic [12:0] SIN_C = 13'd4640;
  localparam logic [15:0] SQRT3_HALF = 16'd56756;

  // trapezoid rows: per phase drive code, 2'b01 plus, 2'b11 minus, 2'b00 float
  localparam logic [1:0] TR_P = 2'b01;
  localparam logic [1:0] TR_M = 2'b11;
  localparam logic [1:0] TR_Z = 2'b00;

  function automatic logic [5:0] trap_row(input logic [2:0] sec);
    logic [5:0] r;
    begin
      case (sec)
        3'd0: r = {TR_M, TR_P, TR_Z};
        3'd1: r = {TR_Z, TR_P, TR_M};
        3'd2: r = {TR_P, TR_Z, TR_M};
        3'd3: r = {TR_P, TR_M, TR_Z};
        3'd4: r = {TR_Z, TR_M, TR_P};
        3'd5: r = {TR_M, TR_Z, TR_P};
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

// ----- rtl/bldc_phase_voltage_modulator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bldc_phase_voltage_modulator
// turns a q/d voltage command, angle and hall sector into three pwm duties
// ----------------------------------------------------------------------------
// One word is worked on at a time. In trapezoid mode the result is valid once
// three bit-serial restoring divisions (load, 16 steps, final) are done, one
// per phase. Space vector mode first adds the shared-multiplier sine and
// cosine, the inverse park and clarke steps and the modulation. The next word
// is taken once the block is idle and the result register is free or being
// read.
// Configuration writes are taken at any cycle and belong between words.
module bldc_phase_voltage_modulator #(
  parameter int unsigned ANGLE_BITS   = 12,
  parameter int unsigned VOLTAGE_BITS = 16
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire  [bpvm_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire  [VOLTAGE_BITS-2:0]             cfg_data_i,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire  signed [VOLTAGE_BITS-1:0]      q_voltage_i,
  input  wire  signed [VOLTAGE_BITS-1:0]      d_voltage_i,
  input  wire  [ANGLE_BITS-1:0]               electric_angle_i,
  input  wire  [2:0]                          hall_sector_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic [15:0]                         duty_u_o,
  output logic [15:0]                         duty_v_o,
  output logic [15:0]                         duty_w_o,
  output logic [2:0]                          phase_on_mask_o,
  output logic                                sector_invalid_o
);
  import bpvm_pkg::*;

  localparam int unsigned VW = VOLTAGE_BITS;
  localparam int unsigned LW = VOLTAGE_BITS - 1;
  localparam int unsigned WW = VW + 20;   // wide signed work width

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SIN1  = 4'd1;
  localparam logic [3:0] S_SIN2  = 4'd2;
  localparam logic [3:0] S_SIN3  = 4'd3;
  localparam logic [3:0] S_SIN4  = 4'd4;
  localparam logic [3:0] S_PARK  = 4'd5;
  localparam logic [3:0] S_PARK2 = 4'd6;
  localparam logic [3:0] S_CLRK  = 4'd7;
  localparam logic [3:0] S_CLRK2 = 4'd8;
  localparam logic [3:0] S_MOD   = 4'd9;
  localparam logic [3:0] S_DLOAD = 4'd10;
  localparam logic [3:0] S_DIV   = 4'd11;
  localparam logic [3:0] S_TRAP  = 4'd12;
  localparam logic [3:0] S_SIN5  = 4'd13;

  logic [3:0] state_q, state_d;

  // configuration
  logic          mode_q, center_q;
  logic [LW-1:0] limit_q, supply_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      center_q <= 1'b1;
      limit_q  <= LW'(3072);
      supply_q <= LW'(3072);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MODE:   mode_q   <= cfg_data_i[0];
        CFG_CENTER: center_q <= cfg_data_i[0];
        CFG_LIMIT:  limit_q  <= cfg_data_i;
        CFG_SUPPLY: supply_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // held state
  logic signed [VW-1:0] hv_q [3];
  logic [2:0]           hmask_q;
  logic                 flag_q;

  // item registers
  logic signed [VW-1:0] uq_q, ud_q;
  logic [15:0]          t_q;
  logic [2:0]           sec_q;

  // sine unit: one multiply per cycle, sin and cos in turn
  logic        sc_sel_q;               // 0 sin, 1 cos
  logic [14:0] x_q;
  logic [1:0]  quad_q;
  logic [15:0] u2_q;
  logic [17:0] p_q;
  logic signed [17:0] sin_q, cos_q;

  logic [15:0] tt;
  logic [13:0] ff;
  logic [14:0] xx;
  assign tt = sc_sel_q ? (t_q + 16'd16384) : t_q;
  assign ff = tt[13:0];
  assign xx = tt[14] ? (15'd16384 - {1'b0, ff}) : {1'b0, ff};

  logic [29:0] m_xx;
  logic [28:0] m_c;
  logic [33:0] m_b;
  logic [32:0] m_a;
  logic [17:0] p_b, p_a;
  assign m_xx = x_q * x_q;
  assign m_c  = SIN_C * u2_q;
  assign p_b  = {2'b0, SIN_B} - {3'b0, m_c[28:14]};
  assign m_b  = p_q * u2_q;
  assign p_a  = {1'b0, SIN_A} - {2'b0, m_b[29:14]};
  assign m_a  = p_q[16:0] * {1'b0, x_q};

  logic signed [17:0] s_val;
  assign s_val = quad_q[1] ? -$signed({1'b0, m_a[31:15]}) : $signed({1'b0, m_a[31:15]});

  // park / clarke
  logic signed [WW-1:0] ua_q, ub_q, acc_q;
  logic signed [WW-1:0] ph_q [3];
  logic signed [WW-1:0] prod;
  logic signed [VW-1:0] mul_a;
  logic signed [17:0]   mul_b;
  logic [1:0]           pk_q;
  always_comb begin
    case (pk_q)
      2'd0: begin mul_a = ud_q; mul_b = cos_q; end
      2'd1: begin mul_a = uq_q; mul_b = sin_q; end
      2'd2: begin mul_a = ud_q; mul_b = sin_q; end
      default: begin mul_a = uq_q; mul_b = cos_q; end
    endcase
  end
  assign prod = WW'(mul_a * mul_b);

  function automatic logic signed [WW-1:0] rsh(input logic signed [WW-1:0] v,
                                               input int unsigned n);
    logic signed [WW-1:0] r;
    begin
      r = (v + (WW'(1) <<< (n - 1))) >>> n;
      return r;
    end
  endfunction

  function automatic logic signed [VW-1:0] satv(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] hi, lo;
    begin
      hi = (WW'(1) <<< (VW - 1)) - WW'(1);
      lo = -(WW'(1) <<< (VW - 1));
      if (v > hi) return hi[VW-1:0];
      if (v < lo) return lo[VW-1:0];
      return v[VW-1:0];
    end
  endfunction

  logic signed [WW-1:0] tb;
  assign tb = WW'(ub_q * $signed({1'b0, SQRT3_HALF}));

  logic signed [WW-1:0] mn, mx;
  always_comb begin
    mn = ph_q[0]; mx = ph_q[0];
    if (ph_q[1] < mn) mn = ph_q[1];
    if (ph_q[2] < mn) mn = ph_q[2];
    if (ph_q[1] > mx) mx = ph_q[1];
    if (ph_q[2] > mx) mx = ph_q[2];
  end

  // trapezoid
  logic signed [WW-1:0] uq_w, abs2, base, tv [3];
  logic [5:0] row;
  assign uq_w = WW'(uq_q);
  assign abs2 = (uq_w < 0) ? -(uq_w <<< 1) : (uq_w <<< 1);
  assign base = center_q ? WW'({1'b0, limit_q}) : abs2;
  assign row  = trap_row(sec_q);
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (row[2*k +: 2])
        TR_P: tv[k] = rsh((uq_w <<< 1) + base, 1);
        TR_M: tv[k] = rsh(base - (uq_w <<< 1), 1);
        default: tv[k] = rsh(base, 1);
      endcase
    end
  end

  // bit-serial restoring divider: (clamped << 16) / supply
  // the remainder starts at the clamped voltage; a nonzero clamped voltage at or
  // above the supply saturates (0/0 is 0), so the quotient always fits 16 bits
  logic [1:0]     ph_sel_q;
  logic [4:0]     cnt_q;
  logic [LW:0]    rem_q;
  logic [15:0]    quo_q;
  logic [15:0]    duty_q [3];
  logic [LW-1:0]  clamp;
  logic signed [VW-1:0] hsel;
  assign hsel = hv_q[ph_sel_q];
  always_comb begin
    if (hsel[VW-1]) clamp = '0;
    else if ({1'b0, hsel[VW-2:0]} > {1'b0, limit_q}) clamp = limit_q;
    else clamp = hsel[VW-2:0];
  end
  logic [LW+1:0] rem_sh, rem_sub;
  assign rem_sh  = {rem_q, 1'b0};
  assign rem_sub = rem_sh - {2'b0, supply_q};

  logic out_busy;
  assign out_busy   = out_valid_o && !out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && !out_busy;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i && in_ready_o) state_d = S_TRAP;
      S_TRAP:  state_d = mode_q ? S_SIN1 : S_DLOAD;
      S_SIN1:  state_d = S_SIN2;
      S_SIN2:  state_d = S_SIN3;
      S_SIN3:  state_d = S_SIN4;
      S_SIN4:  state_d = S_SIN5;
      S_SIN5:  state_d = sc_sel_q ? S_PARK : S_SIN1;
      S_PARK:  state_d = (pk_q == 2'd3) ? S_PARK2 : S_PARK;
      S_PARK2: state_d = S_CLRK;
      S_CLRK:  state_d = S_CLRK2;
      S_CLRK2: state_d = S_MOD;
      S_MOD:   state_d = S_DLOAD;
      S_DLOAD: state_d = S_DIV;
      S_DIV:   if (cnt_q == 5'd0)
                 state_d = (ph_sel_q == 2'd2) ? S_IDLE : S_DLOAD;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_o <= 1'b0;
      hv_q[0] <= '0; hv_q[1] <= '0; hv_q[2] <= '0;
      hmask_q <= 3'b111;
      flag_q  <= 1'b0;
      sc_sel_q <= 1'b0;
      pk_q     <= '0;
      ph_sel_q <= '0;
      cnt_q    <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          sc_sel_q <= 1'b0;
          pk_q     <= '0;
          ph_sel_q <= '0;
        end
        S_TRAP: begin
          flag_q <= 1'b0;
          if (!mode_q) begin
            if (sec_q > 3'd5) flag_q <= 1'b1;
            else begin
              for (int k = 0; k < 3; k++) hv_q[k] <= satv(tv[k]);
              hmask_q <= {row[5:4] != TR_Z, row[3:2] != TR_Z, row[1:0] != TR_Z};
            end
          end
        end
        S_SIN5: sc_sel_q <= 1'b1;
        S_PARK: pk_q <= pk_q + 2'd1;
        S_MOD: begin
          for (int k = 0; k < 3; k++)
            hv_q[k] <= center_q ?
              satv(rsh((ph_q[k] <<< 1) + WW'({1'b0, limit_q}) - (mx + mn), 1)) :
              satv(ph_q[k] - mn);
          hmask_q <= 3'b111;
        end
        S_DLOAD: cnt_q <= 5'd16;
        S_DIV: begin
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == 5'd0) begin
            ph_sel_q <= ph_sel_q + 2'd1;
            if (ph_sel_q == 2'd2) out_valid_o <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        uq_q  <= q_voltage_i;
        ud_q  <= d_voltage_i;
        t_q   <= 16'(electric_angle_i) << (16 - ANGLE_BITS);
        sec_q <= hall_sector_i;
      end
      S_SIN1: begin x_q <= xx; quad_q <= tt[15:14]; end
      S_SIN2: u2_q <= m_xx[29:14];
      S_SIN3: p_q <= p_b;
      S_SIN4: p_q <= p_a;
      S_SIN5: if (sc_sel_q) cos_q <= s_val; else sin_q <= s_val;
      S_PARK: begin
        case (pk_q)
          2'd0: acc_q <= prod;
          2'd1: ua_q <= rsh(acc_q - prod, 15);
          2'd2: acc_q <= prod;
          default: ub_q <= rsh(acc_q + prod, 15);
        endcase
      end
      S_PARK2: acc_q <= -(ua_q <<< 15);
      S_CLRK: begin
        ph_q[0] <= ua_q;
        ph_q[1] <= rsh(acc_q + tb, 16);
        ph_q[2] <= rsh(acc_q - tb, 16);
      end
      S_DLOAD: begin
        rem_q <= {1'b0, clamp};
        quo_q <= '0;
      end
      S_DIV: begin
        if (cnt_q != 5'd0) begin
          if (!rem_sub[LW+1]) begin
            rem_q <= rem_sub[LW:0];
            quo_q <= {quo_q[14:0], 1'b1};
          end else begin
            rem_q <= rem_sh[LW:0];
            quo_q <= {quo_q[14:0], 1'b0};
          end
        end else begin
          if (supply_q == '0) duty_q[ph_sel_q] <= (clamp != '0) ? 16'hFFFF : 16'h0;
          else if (clamp >= supply_q) duty_q[ph_sel_q] <= 16'hFFFF;
          else duty_q[ph_sel_q] <= quo_q;
        end
      end
      default: ;
    endcase
  end

  assign duty_u_o         = duty_q[0];
  assign duty_v_o         = duty_q[1];
  assign duty_w_o         = duty_q[2];
  assign phase_on_mask_o  = hmask_q;
  assign sector_invalid_o = flag_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o) else $error("accept while busy");
  a_mask_svm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mode_q) |-> (hmask_q == 3'b111)) else $error("svm mask");
  a_flag_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && sector_invalid_o) |-> !mode_q) else $error("flag in svm");
endmodule
`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// bench for the phase voltage modulator: trapezoid and space vector modes,
// every config register, random words under handshake stalls, field checks
// against a bit-exact duty predictor
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [15:0] duty_u;
  logic [15:0] duty_v;
  logic [15:0] duty_w;
  logic [2:0]  phase_mask;
  logic        bad_sector;
} duty_word_t;

class duty_scoreboard;
  duty_word_t  pending_duties[$];
  int          fail_count;
  int          results_seen;
  int          trap_words;
  int          svm_words;
  logic        svm_mode;
  logic        center_mode;
  logic [14:0] limit_v;
  logic [14:0] supply_v;
  int          hold_u;
  int          hold_v;
  int          hold_w;
  logic [2:0]  hold_mask;

  function new();
    svm_mode    = 1'b0;
    center_mode = 1'b1;
    limit_v     = 15'd3072;
    supply_v    = 15'd3072;
    hold_u      = 0;
    hold_v      = 0;
    hold_w      = 0;
    hold_mask   = 3'd7;
  endfunction

  function void write_reg(logic [1:0] idx, logic [14:0] data);
    case (idx)
      bpvm_pkg::CFG_MODE:   svm_mode    = data[0];
      bpvm_pkg::CFG_CENTER: center_mode = data[0];
      bpvm_pkg::CFG_LIMIT:  limit_v     = data;
      default:              supply_v    = data;
    endcase
  endfunction

  // round half up: add half, then floor shift
  function longint rnd_shift(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function int sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  // quintic quarter-wave sine, Q1.15
  function longint sine_q15(logic [15:0] t);
    longint unsigned f, x, u2, p, s;
    f  = t[13:0];
    x  = t[14] ? 16384 - f : f;
    u2 = (x * x) >> 14;
    p  = (4640 * u2) >> 14;
    p  = 42047 - p;
    p  = (p * u2) >> 14;
    p  = 102944 - p;
    s  = (p * x) >> 15;
    return t[15] ? -longint'(s) : longint'(s);
  endfunction

  function logic [15:0] duty_of(int v);
    longint c;
    longint q;
    c = v;
    if (c < 0) c = 0;
    if (c > limit_v) c = limit_v;
    if (supply_v == 0) return (c > 0) ? 16'hFFFF : 16'h0;
    q = (c << 16) / supply_v;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  function void note_word(logic signed [15:0] uq_in, logic signed [15:0] ud_in,
                          logic [11:0] angle, logic [2:0] sector);
    duty_word_t exp_w;
    longint uq, ud, base, s, c, ua, ub, mn, mx;
    longint ph[3];
    int drive[3];
    int v[3];
    logic [15:0] t;
    exp_w = '0;
    uq = uq_in;
    ud = ud_in;
    if (!svm_mode) begin
      trap_words++;
      if (sector > 5) begin
        exp_w.bad_sector = 1'b1;
      end else begin
        case (sector)
          3'd0: drive = '{0, 1, -1};
          3'd1: drive = '{-1, 1, 0};
          3'd2: drive = '{-1, 0, 1};
          3'd3: drive = '{0, -1, 1};
          3'd4: drive = '{1, -1, 0};
          default: drive = '{1, 0, -1};
        endcase
        base = center_mode ? longint'(limit_v) : 2 * (uq < 0 ? -uq : uq);
        hold_mask = '0;
        for (int k = 0; k < 3; k++) begin
          v[k] = sat16(rnd_shift(2 * drive[k] * uq + base, 1));
          if (drive[k] != 0) hold_mask[k] = 1'b1;
        end
        hold_u = v[0];
        hold_v = v[1];
        hold_w = v[2];
      end
    end else begin
      svm_words++;
      t = {angle, 4'b0};
      s = sine_q15(t);
      c = sine_q15(t + 16'd16384);
      ua = rnd_shift(ud * c - uq * s, 15);
      ub = rnd_shift(ud * s + uq * c, 15);
      ph[0] = ua;
      ph[1] = rnd_shift(-32768 * ua + 56756 * ub, 16);
      ph[2] = rnd_shift(-32768 * ua - 56756 * ub, 16);
      mn = ph[0];
      mx = ph[0];
      for (int k = 1; k < 3; k++) begin
        if (ph[k] < mn) mn = ph[k];
        if (ph[k] > mx) mx = ph[k];
      end
      for (int k = 0; k < 3; k++) begin
        if (center_mode) v[k] = sat16(rnd_shift(2 * ph[k] + limit_v - (mx + mn), 1));
        else v[k] = sat16(ph[k] - mn);
      end
      hold_u = v[0];
      hold_v = v[1];
      hold_w = v[2];
      hold_mask = 3'd7;
    end
    exp_w.duty_u     = duty_of(hold_u);
    exp_w.duty_v     = duty_of(hold_v);
    exp_w.duty_w     = duty_of(hold_w);
    exp_w.phase_mask = hold_mask;
    pending_duties.push_back(exp_w);
  endfunction

  function void check_word(duty_word_t got);
    duty_word_t exp_w;
    results_seen++;
    if (pending_duties.size() == 0) begin
      $error("unexpected result word: duty_u %0d duty_v %0d duty_w %0d",
             got.duty_u, got.duty_v, got.duty_w);
      fail_count++;
      return;
    end
    exp_w = pending_duties.pop_front();
    if (got.duty_u !== exp_w.duty_u) begin
      $error("duty_u expected %0d actual %0d", exp_w.duty_u, got.duty_u);
      fail_count++;
    end
    if (got.duty_v !== exp_w.duty_v) begin
      $error("duty_v expected %0d actual %0d", exp_w.duty_v, got.duty_v);
      fail_count++;
    end
    if (got.duty_w !== exp_w.duty_w) begin
      $error("duty_w expected %0d actual %0d", exp_w.duty_w, got.duty_w);
      fail_count++;
    end
    if (got.phase_mask !== exp_w.phase_mask) begin
      $error("phase_on_mask expected %0d actual %0d", exp_w.phase_mask, got.phase_mask);
      fail_count++;
    end
    if (got.bad_sector !== exp_w.bad_sector) begin
      $error("sector_invalid expected %0d actual %0d", exp_w.bad_sector, got.bad_sector);
      fail_count++;
    end
  endfunction
endclass

module tb;
  import bpvm_pkg::*;

  localparam int CycleLimit = 1000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [14:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] q_voltage_i = '0;
  logic signed [15:0] d_voltage_i = '0;
  logic [11:0]        electric_angle_i = '0;
  logic [2:0]         hall_sector_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [15:0]        duty_u_o;
  logic [15:0]        duty_v_o;
  logic [15:0]        duty_w_o;
  logic [2:0]         phase_on_mask_o;
  logic               sector_invalid_o;

  duty_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold = 0;
  int cycle_count = 0;

  bldc_phase_voltage_modulator DUT (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .q_voltage_i, .d_voltage_i, .electric_angle_i,
    .hall_sector_i, .out_valid_o, .out_ready_i, .duty_u_o, .duty_v_o, .duty_w_o,
    .phase_on_mask_o, .sector_invalid_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb failed");
      $finish;
    end
  end

  // result side: check, then pick ready for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_word({duty_u_o, duty_v_o, duty_w_o, phase_on_mask_o, sector_invalid_o});
      if (recv_hold > 0) begin
        recv_hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // stop offering words and wait until every word has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_duties.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [14:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_setting(logic mode, logic ctr, logic [14:0] lim, logic [14:0] sup);
    drain();
    write_cfg(CFG_MODE, {14'd0, mode});
    write_cfg(CFG_CENTER, {14'd0, ctr});
    write_cfg(CFG_LIMIT, lim);
    write_cfg(CFG_SUPPLY, sup);
  endtask

  task automatic send_word(logic [15:0] uq, logic [15:0] ud, logic [11:0] ang,
                           logic [2:0] sec);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    q_voltage_i      <= uq;
    d_voltage_i      <= ud;
    electric_angle_i <= ang;
    hall_sector_i    <= sec;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(uq, ud, ang, sec);
  endtask

  function automatic logic [15:0] rand_volt();
    case ($urandom_range(3))
      0: return 16'($urandom_range(65535));
      1: return 16'($signed($urandom_range(1024)) - 512);
      2: return 16'($signed($urandom_range(8192)) - 4096);
      default: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
    endcase
  endfunction

  task automatic send_random();
    logic [2:0] sec;
    sec = ($urandom_range(9) == 0) ? 3'(6 + $urandom_range(1)) : 3'($urandom_range(5));
    send_word(rand_volt(), rand_volt(), 12'($urandom_range(4095)), sec);
  endtask

  initial begin
    logic [14:0] lim, sup;
    logic [15:0] dq[3];
    int          ang_pts[5];
    dq = '{16'h7FFF, 16'h8000, 16'h0000};
    ang_pts = '{0, 1024, 2048, 3072, 4095};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // an invalid sector straight after reset returns the reset-time hold
    send_word(16'h0100, 16'h0, 12'd0, 3'd7);
    for (int s = 0; s < 6; s++) send_word(16'h0300, 16'h0, 12'd0, 3'(s));
    foreach (dq[i]) send_word(dq[i], 16'h0, 12'd0, 3'(i));
    send_word(16'h8000, 16'h0, 12'd0, 3'd6);
    write_cfg(CFG_CENTER, 15'd0);
    send_word(16'h8000, 16'h7FFF, 12'd0, 3'd1);
    send_word(16'h7FFF, 16'h0, 12'd0, 3'd4);
    load_setting(1'b1, 1'b1, 15'd32767, 15'd32767);
    foreach (ang_pts[i]) send_word(16'h7FFF, dq[i % 3], 12'(ang_pts[i]), 3'd7);
    write_cfg(CFG_CENTER, 15'd0);
    send_word(16'h8000, 16'h8000, 12'd512, 3'd0);
    send_word(16'h0400, 16'h7FFF, 12'd3500, 3'd6);
    // zero supply in trapezoid mode
    load_setting(1'b0, 1'b0, 15'd32767, 15'd0);
    send_word(16'h1000, 16'h0, 12'd0, 3'd2);
    send_word(16'h0000, 16'h0, 12'd0, 3'd5);

    for (int p = 0; p < 12; p++) begin
      case (p)
        0: begin lim = 15'd32767; sup = 15'd1; end
        1: begin lim = 15'd0; sup = 15'd32767; end
        2: begin lim = 15'd3072; sup = 15'd3072; end
        3: begin lim = 15'd32767; sup = 15'd0; end
        default: begin
          lim = 15'($urandom_range(32767));
          sup = 15'($urandom_range(1, 32767));
        end
      endcase
      send_idle_pct = (p < 4) ? 12 : (p < 8) ? 83 : 0;
      recv_idle_pct = (p < 4) ? 83 : (p < 8) ? 12 : 0;
      load_setting(p[0], p[1], lim, sup);
      if (p == 9) recv_hold = 400;
      repeat (130) send_random();
    end

    in_valid_i <= 1'b0;
    while (sb.pending_duties.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("covered %0d trapezoid and %0d space vector words, %0d results checked",
             sb.trap_words, sb.svm_words, sb.results_seen);
    $display("settings swept incl. zero and full limit, zero and unit supply");
    if (sb.fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/bpvm_pkg.sv
rtl/bldc_phase_voltage_modulator.sv
bench/tb.sv
